FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the odometry core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/ddo_pkg.sv
// Types, constants and helper functions of the odometry core.
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

    localparam logic [19:0] TPM_RST = 20'd4900;
    localparam logic [23:0] BW_RST  = 24'd500000;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_TPM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BW  = 1'b1;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int CORDIC_W         = 50;

    // Q3.28 angle constants
    localparam logic [30:0] TWO_PI_Q  = 31'd1686629713;
    localparam logic [30:0] PI_Q      = 31'd843314857;
    localparam logic [30:0] HALF_PI_Q = 31'd421657428;
    localparam logic [35:0] TWO_PI_X2 = 36'd3373259426;

    localparam logic [29:0] KINV_Q30   = 30'd652032874;
    localparam logic [19:0] SCALE_1E6  = 20'd1000000;
    localparam logic [27:0] SCALE_5P12 = 28'd244140625;

    // divider geometry
    localparam int DIV_NUM_W = 89;
    localparam int DIV_DEN_W = 68;
    localparam int DIV_Q_W   = 48;
    localparam int DIV_LEN_W = 7;

    localparam logic [DIV_LEN_W-1:0] LEN_DIST = 7'd48;
    localparam logic [DIV_LEN_W-1:0] LEN_HEAD = 7'd81;
    localparam logic [DIV_LEN_W-1:0] LEN_LIN  = 7'd68;
    localparam logic [DIV_LEN_W-1:0] LEN_ANG  = 7'd89;

    typedef enum logic [1:0] {
        DIV_PLAIN,
        DIV_CAP,
        DIV_MOD
    } t_div_mode;

    typedef struct packed {
        logic                 start;
        t_div_mode            mode;
        logic [DIV_LEN_W-1:0] len;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_sts;

    // atan(2^-i) in Q3.28
    function automatic logic [27:0] atan_q28(input logic [4:0] i);
        logic [27:0] v;
        case (i)
            5'd0:  v = 28'd210828714;
            5'd1:  v = 28'd124459457;
            5'd2:  v = 28'd65760959;
            5'd3:  v = 28'd33381290;
            5'd4:  v = 28'd16755422;
            5'd5:  v = 28'd8385879;
            5'd6:  v = 28'd4193963;
            5'd7:  v = 28'd2097109;
            5'd8:  v = 28'd1048571;
            5'd9:  v = 28'd524287;
            5'd10: v = 28'd262144;
            5'd11: v = 28'd131072;
            5'd12: v = 28'd65536;
            5'd13: v = 28'd32768;
            5'd14: v = 28'd16384;
            5'd15: v = 28'd8192;
            5'd16: v = 28'd4096;
            5'd17: v = 28'd2048;
            5'd18: v = 28'd1024;
            5'd19: v = 28'd512;
            5'd20: v = 28'd256;
            5'd21: v = 28'd128;
            5'd22: v = 28'd64;
            5'd23: v = 28'd32;
            5'd24: v = 28'd16;
            5'd25: v = 28'd8;
            5'd26: v = 28'd4;
            5'd27: v = 28'd2;
            5'd28: v = 28'd1;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

    // reduce an angle in [-4pi, 4pi) to [-pi, pi)
    function automatic logic signed [30:0] wrap_angle(input logic signed [33:0] a);
        logic [35:0] b;
        b = {{2{a[33]}}, a} + TWO_PI_X2;
        if (b >= TWO_PI_X2) b = b - TWO_PI_X2;
        if (b >= 36'(TWO_PI_Q)) b = b - 36'(TWO_PI_Q);
        if (b >= 36'(PI_Q)) b = b - 36'(TWO_PI_Q);
        return b[30:0];
    endfunction

    function automatic logic [47:0] sat48(input logic signed [50:0] v);
        logic [47:0] r;
        if (v > 51'sh0_7FFF_FFFF_FFFF) r = 48'h7FFF_FFFF_FFFF;
        else if (v < -51'sh0_8000_0000_0000) r = 48'h8000_0000_0000;
        else r = v[47:0];
        return r;
    endfunction

    // quotient clipped to 2^31
    function automatic logic [31:0] vel_cap(input logic [47:0] q, input logic ovf);
        logic [31:0] r;
        if (ovf || q > 48'h0000_8000_0000) r = 32'h8000_0000;
        else r = q[31:0];
        return r;
    endfunction

    function automatic logic [31:0] sat_vel(input logic neg, input logic [31:0] m);
        logic [31:0] r;
        if (neg) r = ~m + 32'd1;
        else if (m >= 32'h7FFF_FFFF) r = 32'h7FFF_FFFF;
        else r = m;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ddo_mul.sv
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module ddo_mul (
    input  logic        i_clk,
    input  logic [33:0] i_a,
    input  logic [29:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;
endmodule

`default_nettype wire

FILE: hw/rtl/ddo_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, with a modular mode and an overflow flag.
`timescale 1ns / 1ps
`default_nettype none

module ddo_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ddo_pkg::t_div_req                i_req,
    input  logic [ddo_pkg::DIV_NUM_W-1:0]    i_num,
    input  logic [ddo_pkg::DIV_DEN_W-1:0]    i_den,
    output ddo_pkg::t_div_sts                o_sts,
    output logic [ddo_pkg::DIV_Q_W-1:0]      o_quo
);
    import ddo_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic                 r_ovf;
    t_div_mode            r_mode;
    logic [DIV_LEN_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_Q_W-1:0]   r_q;

    logic [DIV_DEN_W:0]   rem2;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;
    logic [DIV_DEN_W-1:0] rem_n;
    logic [31:0]          mq2;
    logic [31:0]          mq_n;
    logic [DIV_Q_W-1:0]   q_n;
    logic                 ovf_n;

    always_comb begin
        rem2  = {r_rem, r_num[DIV_NUM_W-1]};
        diff  = rem2 - {1'b0, r_den};
        ge    = rem2 >= {1'b0, r_den};
        rem_n = ge ? diff[DIV_DEN_W-1:0] : rem2[DIV_DEN_W-1:0];
        // quotient kept modulo 2*pi: 2q+b stays below twice the modulus
        mq2   = {r_q[30:0], ge};
        mq_n  = (mq2 >= {1'b0, TWO_PI_Q}) ? mq2 - {1'b0, TWO_PI_Q} : mq2;
        if (r_mode == DIV_MOD) begin
            q_n   = DIV_Q_W'(mq_n);
            ovf_n = r_ovf;
        end else begin
            q_n   = {r_q[DIV_Q_W-2:0], ge};
            ovf_n = r_ovf | r_q[DIV_Q_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == DIV_LEN_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_mode <= i_req.mode;
                r_cnt  <= i_req.len;
            end else if (r_busy) begin
                r_num <= {r_num[DIV_NUM_W-2:0], 1'b0};
                r_rem <= rem_n;
                r_q   <= q_n;
                r_ovf <= ovf_n;
                r_cnt <= r_cnt - DIV_LEN_W'(1);
                if (r_cnt == DIV_LEN_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.ovf  = r_ovf;
    assign o_quo      = r_q;
endmodule

`default_nettype wire

FILE: hw/rtl/ddo_cordic.sv
// Iterative CORDIC rotation, one micro-rotation per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ddo_cordic #(
    parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [ddo_pkg::CORDIC_W-1:0] i_x,
    input  logic signed [31:0]                  i_z,
    output logic                                o_done,
    output logic signed [ddo_pkg::CORDIC_W-1:0] o_x,
    output logic signed [ddo_pkg::CORDIC_W-1:0] o_y
);
    import ddo_pkg::*;

    localparam int CNT_W = $clog2(STEPS);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_i;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [31:0]         r_z;

    logic [4:0]                 sh;
    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [31:0]         at;
    logic signed [31:0]         half;
    logic signed [31:0]         pi_s;

    always_comb begin
        sh   = 5'(r_i);
        xs   = r_x >>> sh;
        ys   = r_y >>> sh;
        at   = $signed({4'b0, atan_q28(sh)});
        half = $signed({1'b0, HALF_PI_Q});
        pi_s = $signed({1'b0, PI_Q});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_i == CNT_W'(STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_y    <= '0;
                // fold into the right half plane
                if (i_z > half) begin
                    r_x <= -i_x;
                    r_z <= i_z - pi_s;
                end else if (i_z < -half) begin
                    r_x <= -i_x;
                    r_z <= i_z + pi_s;
                end else begin
                    r_x <= i_x;
                    r_z <= i_z;
                end
            end else if (r_busy) begin
                if (r_z >= 0) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                r_i <= r_i + CNT_W'(1);
                if (r_i == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
endmodule

`default_nettype wire

FILE: hw/rtl/diff_drive_odometry_core.sv
// Top level of the differential-drive odometry core: sequencer, state and outputs.
//
//  channel  | signals                                   | dir | width
//  ---------+-------------------------------------------+-----+---------------------
//  in       | i_in_valid/o_in_ready, counts, elapsed_us | in  | 32 + 32 + 24
//  out      | o_out_valid/i_out_ready, pose, velocities | out | 48 + 48 + 31 + 32 + 32 + 1
//  cfg      | i_cfg_we, i_cfg_idx, i_cfg_data           | in  | 1 + 1 + 24
//
// Most of the work of an item lies in the radix-2 divider (one quotient bit a cycle
// over 48, 81, 68 and 89 bit numerators; the last two divisions are skipped when
// elapsed_us is zero), with 9 multiplier passes. Input is taken only in idle; a
// finished result waits in the output register while the next item is accepted,
// and the last step of that item stalls until the register is read. Reset is
// synchronous: it clears the pose, the last counts and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module diff_drive_odometry_core #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [31:0]                i_left_count,
    input  logic signed [31:0]                i_right_count,
    input  logic [23:0]                       i_elapsed_us,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [47:0]                o_pos_x,
    output logic signed [47:0]                o_pos_y,
    output logic signed [30:0]                o_heading,
    output logic signed [31:0]                o_linear_velocity,
    output logic signed [31:0]                o_angular_velocity,
    output logic                              o_time_zero,
    input  logic                              i_cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ddo_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ddo_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_M_TB, S_M_TE, S_M_HN, S_M_LN, S_M_AN, S_M_AH, S_M_AL, S_M_SUM,
        S_DIV_D, S_WAIT_D, S_DIV_H, S_WAIT_H, S_DIV_L, S_WAIT_L, S_DIV_A, S_WAIT_A,
        S_K_HI, S_K_LO, S_K_SUM, S_CORDIC, S_WAIT_C, S_ACC
    } t_state;

    t_state r_state;

    logic [19:0] r_tpm;
    logic [23:0] r_bw;
    logic [31:0] r_last_left;
    logic [31:0] r_last_right;
    logic [47:0] r_acc_x;
    logic [47:0] r_acc_y;
    logic signed [30:0] r_acc_h;

    // per-item working registers
    logic [32:0]  r_sm;
    logic [32:0]  r_tm;
    logic         r_s_neg;
    logic         r_t_neg;
    logic [23:0]  r_e;
    logic         r_e_zero;
    logic [43:0]  r_tb;
    logic [43:0]  r_te;
    logic [52:0]  r_hn;
    logic [52:0]  r_ln;
    logic [60:0]  r_an;
    logic [45:0]  r_ah;
    logic [67:0]  r_tbe;
    logic [47:0]  r_dmag;
    logic [30:0]  r_m;
    logic [31:0]  r_lin_q;
    logic [31:0]  r_ang_q;
    logic [47:0]  r_khi;
    logic [47:0]  r_pre;
    logic signed [30:0] r_phi;

    logic               r_out_valid;
    logic [47:0]        r_pos_x;
    logic [47:0]        r_pos_y;
    logic signed [30:0] r_heading;
    logic [31:0]        r_lin_v;
    logic [31:0]        r_ang_v;
    logic               r_time_zero;

    logic [19:0] tpm_eff;
    logic [23:0] bw_eff;
    logic        in_acc;
    logic [31:0] dl;
    logic [31:0] dr;
    logic [32:0] s33;
    logic [32:0] t33;
    logic [33:0] mul_a;
    logic [29:0] mul_b;
    logic [63:0] mul_p;

    t_div_req              div_req;
    t_div_sts              div_sts;
    logic [DIV_NUM_W-1:0]  div_num;
    logic [DIV_DEN_W-1:0]  div_den;
    logic [DIV_Q_W-1:0]    div_quo;

    logic                       cor_start;
    logic signed [CORDIC_W-1:0] cor_x;
    logic signed [31:0]         cor_z;
    logic                       cor_done;
    logic signed [CORDIC_W-1:0] cor_ox;
    logic signed [CORDIC_W-1:0] cor_oy;

    logic [30:0]  m_fix;
    logic         out_free;
    logic         head_ok;
    logic         div_wait;

    assign tpm_eff    = (r_tpm == '0) ? 20'd1 : r_tpm;
    assign bw_eff     = (r_bw == '0) ? 24'd1 : r_bw;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        dl  = i_left_count - r_last_left;
        dr  = i_right_count - r_last_right;
        s33 = {dl[31], dl} + {dr[31], dr};
        t33 = {dr[31], dr} - {dl[31], dl};
        m_fix = (r_t_neg && div_quo[30:0] != '0) ? TWO_PI_Q - div_quo[30:0] : div_quo[30:0];
    end

    // multiplier operand select
    always_comb begin
        unique case (r_state)
            S_M_TB:  begin mul_a = 34'(bw_eff);        mul_b = 30'(tpm_eff);    end
            S_M_TE:  begin mul_a = 34'(r_e);           mul_b = 30'(tpm_eff);    end
            S_M_HN:  begin mul_a = 34'(r_tm);          mul_b = 30'(SCALE_1E6);  end
            S_M_LN:  begin mul_a = 34'(r_sm);          mul_b = 30'(SCALE_1E6);  end
            S_M_AN:  begin mul_a = 34'(r_tm);          mul_b = 30'(SCALE_5P12); end
            S_M_AH:  begin mul_a = 34'(r_tb[43:22]);   mul_b = 30'(r_e);        end
            S_M_AL:  begin mul_a = 34'(r_tb[21:0]);    mul_b = 30'(r_e);        end
            S_K_HI:  begin mul_a = 34'(r_dmag[47:30]); mul_b = KINV_Q30;        end
            S_K_LO:  begin mul_a = 34'(r_dmag[29:0]);  mul_b = KINV_Q30;        end
            default: begin mul_a = '0;                 mul_b = '0;              end
        endcase
    end

    // divider request select; numerators are left-aligned in the shift register
    always_comb begin
        div_req.start = 1'b0;
        div_req.mode  = DIV_PLAIN;
        div_req.len   = LEN_DIST;
        div_num       = '0;
        div_den       = '0;
        unique case (r_state)
            S_DIV_D: begin
                div_req = '{start: 1'b1, mode: DIV_PLAIN, len: LEN_DIST};
                div_num = {r_sm, 56'b0};
                div_den = 68'(tpm_eff);
            end
            S_DIV_H: begin
                div_req = '{start: 1'b1, mode: DIV_MOD, len: LEN_HEAD};
                div_num = {r_hn, 36'b0};
                div_den = 68'(r_tb);
            end
            S_DIV_L: begin
                div_req = '{start: 1'b1, mode: DIV_CAP, len: LEN_LIN};
                div_num = {r_ln, 36'b0};
                div_den = 68'(r_te);
            end
            S_DIV_A: begin
                div_req = '{start: 1'b1, mode: DIV_CAP, len: LEN_ANG};
                div_num = {r_an, 28'b0};
                div_den = r_tbe;
            end
            default: ;
        endcase
    end

    assign cor_start = (r_state == S_CORDIC);
    assign cor_x     = r_s_neg ? -$signed({2'b0, r_pre}) : $signed({2'b0, r_pre});
    assign cor_z     = {r_phi[30], r_phi};

    ddo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_sts   (div_sts),
        .o_quo   (div_quo)
    );

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_x     (cor_x),
        .i_z     (cor_z),
        .o_done  (cor_done),
        .o_x     (cor_ox),
        .o_y     (cor_oy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tpm        <= TPM_RST;
            r_bw         <= BW_RST;
            r_last_left  <= '0;
            r_last_right <= '0;
            r_acc_x      <= '0;
            r_acc_y      <= '0;
            r_acc_h      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TPM: r_tpm <= i_cfg_data[19:0];
                    REG_BW:  r_bw  <= i_cfg_data;
                    default: ;
                endcase
            end

            // the load in S_ACC covers a transfer in the same cycle
            if (r_out_valid && i_out_ready && r_state != S_ACC) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_last_left  <= i_left_count;
                        r_last_right <= i_right_count;
                        r_s_neg      <= s33[32];
                        r_t_neg      <= t33[32];
                        r_sm         <= s33[32] ? -s33 : s33;
                        r_tm         <= t33[32] ? -t33 : t33;
                        r_e          <= i_elapsed_us;
                        r_e_zero     <= (i_elapsed_us == '0);
                        r_state      <= S_M_TB;
                    end
                end
                S_M_TB:  r_state <= S_M_TE;
                S_M_TE:  begin r_tb <= mul_p[43:0]; r_state <= S_M_HN; end
                S_M_HN:  begin r_te <= mul_p[43:0]; r_state <= S_M_LN; end
                S_M_LN:  begin r_hn <= mul_p[52:0]; r_state <= S_M_AN; end
                S_M_AN:  begin r_ln <= mul_p[52:0]; r_state <= S_M_AH; end
                S_M_AH:  begin r_an <= mul_p[60:0]; r_state <= S_M_AL; end
                S_M_AL:  begin r_ah <= mul_p[45:0]; r_state <= S_M_SUM; end
                S_M_SUM: begin
                    // width*ticks*elapsed from two 22-bit halves
                    r_tbe   <= {r_ah, 22'b0} + 68'(mul_p[45:0]);
                    r_state <= S_DIV_D;
                end
                S_DIV_D:  r_state <= S_WAIT_D;
                S_WAIT_D: begin
                    if (div_sts.done) begin
                        r_dmag  <= div_quo;
                        r_state <= S_DIV_H;
                    end
                end
                S_DIV_H:  r_state <= S_WAIT_H;
                S_WAIT_H: begin
                    if (div_sts.done) begin
                        r_m     <= m_fix;
                        r_state <= r_e_zero ? S_K_HI : S_DIV_L;
                    end
                end
                S_DIV_L:  r_state <= S_WAIT_L;
                S_WAIT_L: begin
                    if (div_sts.done) begin
                        r_lin_q <= vel_cap(div_quo, div_sts.ovf);
                        r_state <= S_DIV_A;
                    end
                end
                S_DIV_A:  r_state <= S_WAIT_A;
                S_WAIT_A: begin
                    if (div_sts.done) begin
                        r_ang_q <= vel_cap(div_quo, div_sts.ovf);
                        r_state <= S_K_HI;
                    end
                end
                S_K_HI: r_state <= S_K_LO;
                S_K_LO: begin
                    r_khi   <= mul_p[47:0];
                    r_state <= S_K_SUM;
                end
                S_K_SUM: begin
                    // prescale by 1/K, low part floored separately
                    r_pre   <= r_khi + 48'(mul_p[59:30]);
                    r_phi   <= wrap_angle($signed({{3{r_acc_h[30]}}, r_acc_h})
                                          - $signed({3'b0, r_m}));
                    r_state <= S_CORDIC;
                end
                S_CORDIC: r_state <= S_WAIT_C;
                S_WAIT_C: begin
                    if (cor_done) r_state <= S_ACC;
                end
                S_ACC: begin
                    if (out_free) begin
                        r_acc_x     <= sat48($signed({{3{r_acc_x[47]}}, r_acc_x})
                                             + $signed({cor_ox[CORDIC_W-1], cor_ox}));
                        r_acc_y     <= sat48($signed({{3{r_acc_y[47]}}, r_acc_y})
                                             + $signed({cor_oy[CORDIC_W-1], cor_oy}));
                        r_acc_h     <= wrap_angle($signed({{3{r_acc_h[30]}}, r_acc_h})
                                                  + $signed({3'b0, r_m}));
                        r_pos_x     <= sat48($signed({{3{r_acc_x[47]}}, r_acc_x})
                                             + $signed({cor_ox[CORDIC_W-1], cor_ox}));
                        r_pos_y     <= sat48($signed({{3{r_acc_y[47]}}, r_acc_y})
                                             + $signed({cor_oy[CORDIC_W-1], cor_oy}));
                        r_heading   <= wrap_angle($signed({{3{r_acc_h[30]}}, r_acc_h})
                                                  + $signed({3'b0, r_m}));
                        r_lin_v     <= r_e_zero ? 32'd0 : sat_vel(r_s_neg, r_lin_q);
                        r_ang_v     <= r_e_zero ? 32'd0 : sat_vel(r_t_neg, r_ang_q);
                        r_time_zero <= r_e_zero;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_pos_x            = r_pos_x;
    assign o_pos_y            = r_pos_y;
    assign o_heading          = r_heading;
    assign o_linear_velocity  = r_lin_v;
    assign o_angular_velocity = r_ang_v;
    assign o_time_zero        = r_time_zero;

    assign head_ok = ($signed({r_acc_h[30], r_acc_h}) < $signed({1'b0, PI_Q}))
                  && ($signed({r_acc_h[30], r_acc_h}) >= -$signed({1'b0, PI_Q}));

    assign div_wait = (r_state == S_WAIT_D) || (r_state == S_WAIT_H)
                   || (r_state == S_WAIT_L) || (r_state == S_WAIT_A);

    `ASSERT_IMPL(a_div_done_wait, div_sts.done, div_wait)
    `ASSERT_NEXT(a_accept_starts, in_acc, r_state == S_M_TB && !o_in_ready)
    `ASSERT_IMPL(a_heading_range, 1'b1, head_ok)
    `ASSERT_NEXT(a_result_load, r_state == S_ACC && out_free, o_out_valid && o_in_ready)
endmodule

`default_nettype wire
